### design/multilevel_multiprobe_hash_set_defines.svh
// Assertion macros for the asserting top-level file.
`ifndef MULTILEVEL_MULTIPROBE_HASH_SET_DEFINES_SVH
`define MULTILEVEL_MULTIPROBE_HASH_SET_DEFINES_SVH

// Condition must hold at every clock edge out of reset.
`define MMHS_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("mmhs check failed");

// Antecedent implies consequent in the same cycle.
`define MMHS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mmhs check failed");

`endif

### design/mmhs_pkg.sv
package mmhs_pkg;

    localparam int INIT_SIZE  = 16;
    localparam int INIT_LOG2  = 4;
    localparam int MAX_HASHES = 4;

    localparam logic [31:0] MUR_C1 = 32'hcc9e2d51;
    localparam logic [31:0] MUR_C2 = 32'h1b873593;
    localparam logic [31:0] MUR_C3 = 32'h85ebca6b;
    localparam logic [31:0] MUR_C4 = 32'hc2b2ae35;
    localparam logic [31:0] MUR_E  = 32'he6546b64;
    localparam logic [31:0] MUR_LEN = 32'd4;

    localparam logic [2:0] CFG_HASH_COUNT = 3'd0;
    localparam logic [2:0] CFG_SEED_0     = 3'd1;
    localparam logic [2:0] CFG_SEED_1     = 3'd2;
    localparam logic [2:0] CFG_SEED_2     = 3'd3;
    localparam logic [2:0] CFG_SEED_3     = 3'd4;

    localparam logic OP_QUERY  = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    localparam int FLAG_OCC   = 64;
    localparam int FLAG_MOVED = 65;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_LEVEL,
        ST_PROBE,
        ST_CHECK,
        ST_MIGDONE
    } state_t;

    typedef struct packed {
        logic        op;
        logic [63:0] key;
    } item_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] data;
        logic [31:0] seed;
        logic [1:0]  tag;
    } hash_req_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] hash;
        logic [1:0]  tag;
    } hash_resp_t;

endpackage

### design/mmhs_front.sv
module mmhs_front
    import mmhs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic        s_tuser,
    output logic        q_valid,
    output item_t       q_item,
    input  logic        q_pop
);

    item_t      buf_reg [2];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = buf_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? ~wr_reg : wr_reg;
        rd_next  = q_pop ? ~rd_reg : rd_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_reg] <= '{op: s_tuser, key: s_tdata};
        end
    end

endmodule

### design/mmhs_hash.sv
module mmhs_hash
    import mmhs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  hash_req_t  req,
    output hash_resp_t resp
);

    function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
        rotl = (x << r) | (x >> (32 - r));
    endfunction

    logic [4:0]  v_reg;
    logic [1:0]  tag_reg [5];
    logic [31:0] seed1_reg, seed2_reg;
    logic [31:0] k1_reg, k2_reg, h3_reg, h4_reg, h5_reg;
    logic [31:0] t3, u3, x5;

    always_comb
    begin
        t3 = rotl(seed2_reg ^ k2_reg, 13);
        t3 = ((t3 << 2) + t3 + MUR_E) ^ MUR_LEN;
        u3 = t3 ^ (t3 >> 16);
        x5 = h4_reg ^ (h4_reg >> 13);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[3:0], req.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg[0] <= req.tag;
        for (int s = 1; s < 5; s++)
        begin
            tag_reg[s] <= tag_reg[s-1];
        end
        seed1_reg <= req.seed;
        seed2_reg <= seed1_reg;
        k1_reg    <= req.data * MUR_C1;
        k2_reg    <= rotl(k1_reg, 15) * MUR_C2;
        h3_reg    <= u3;
        h4_reg    <= h3_reg * MUR_C3;
        h5_reg    <= x5 * MUR_C4;
    end

    assign resp.valid = v_reg[4];
    assign resp.tag   = tag_reg[4];
    assign resp.hash  = h5_reg ^ (h5_reg >> 16);

endmodule

### design/mmhs_engine.sv
module mmhs_engine
    import mmhs_pkg::*;
#(
    parameter int MAX_LEVELS = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        q_valid,
    input  item_t       q_item,
    output logic        q_pop,
    output hash_req_t   hreq,
    input  hash_resp_t  hresp,
    input  logic        m_tready,
    output logic        out_valid,
    output logic        present,
    output logic        status
);

    localparam int TOTAL  = INIT_SIZE * ((1 << MAX_LEVELS) - 1);
    localparam int ADDR_W = $clog2(TOTAL);
    localparam int LVL_W  = $clog2(MAX_LEVELS + 1);
    localparam int IDX_W  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int CNT_W  = INIT_LOG2 + MAX_LEVELS;

    logic [65:0] mem [TOTAL];
    logic [65:0] rdata_reg;
    logic        mem_we;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [65:0] mem_wdata;

    state_t state_reg, state_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [2:0]  hc_reg;
    logic [31:0] seed_reg [4];
    logic        op_reg, op_next;
    logic [63:0] key_reg, key_next, mkey_reg, mkey_next;
    logic [31:0] h_reg [4], h_next [4], mh_reg [4], mh_next [4];
    logic        nest_reg, nest_next;
    logic [LVL_W-1:0] start_reg, start_next, lvl_reg, lvl_next;
    logic [LVL_W-1:0] mstart_reg, mstart_next, mlvl_reg, mlvl_next;
    logic [LVL_W-1:0] live_reg, live_next, oldest_reg, oldest_next;
    logic [1:0]  hi_reg, hi_next, mhi_reg, mhi_next;
    logic        copy_reg, copy_next;
    logic [2:0]  iss_reg, iss_next, rx_reg, rx_next;
    logic [CNT_W-1:0] moved_reg [MAX_LEVELS], moved_next [MAX_LEVELS];
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic        outv_reg, outv_next, pres_reg, pres_next, stat_reg, stat_next;

    logic [2:0]  nh;
    logic [LVL_W-1:0] cur_j, cur_start;
    logic [1:0]  cur_hi;
    logic [63:0] cur_key;
    logic [31:0] cur_h;
    logic [31:0] mask32, base32, size32;

    always_comb
    begin
        if (hc_reg == 3'd0)
            nh = 3'd1;
        else if (hc_reg > 3'(MAX_HASHES))
            nh = 3'(MAX_HASHES);
        else
            nh = hc_reg;
        cur_j     = nest_reg ? mlvl_reg : lvl_reg;
        cur_start = nest_reg ? mstart_reg : start_reg;
        cur_hi    = nest_reg ? mhi_reg : hi_reg;
        cur_key   = nest_reg ? mkey_reg : key_reg;
        cur_h     = nest_reg ? mh_reg[cur_hi] : h_reg[cur_hi];
        mask32    = (32'(INIT_SIZE) << cur_j) - 32'd1;
        base32    = ((32'd1 << cur_j) - 32'd1) << INIT_LOG2;
        size32    = 32'(INIT_SIZE) << lvl_reg;
    end

    always_comb
    begin
        logic do_ret, ret_p, ret_s, do_adv;
        do_ret = 1'b0;
        ret_p  = 1'b0;
        ret_s  = 1'b0;
        do_adv = 1'b0;

        state_next  = state_reg;
        clr_next    = clr_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        mkey_next   = mkey_reg;
        h_next      = h_reg;
        mh_next     = mh_reg;
        nest_next   = nest_reg;
        start_next  = start_reg;
        lvl_next    = lvl_reg;
        mstart_next = mstart_reg;
        mlvl_next   = mlvl_reg;
        live_next   = live_reg;
        oldest_next = oldest_reg;
        hi_next     = hi_reg;
        mhi_next    = mhi_reg;
        copy_next   = copy_reg;
        iss_next    = iss_reg;
        rx_next     = rx_reg;
        moved_next  = moved_reg;
        addr_next   = addr_reg;
        outv_next   = m_tready ? 1'b0 : outv_reg;
        pres_next   = pres_reg;
        stat_next   = stat_reg;
        q_pop       = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = addr_reg;
        mem_wdata   = {2'b01, cur_key};
        mem_raddr   = addr_reg;
        hreq.valid  = 1'b0;
        hreq.data   = cur_key[31:0];
        hreq.seed   = seed_reg[iss_reg[1:0]];
        hreq.tag    = iss_reg[1:0];

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                if (clr_reg == ADDR_W'(TOTAL - 1))
                    state_next = ST_IDLE;
                else
                    clr_next = clr_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (q_valid && (!outv_reg || m_tready))
                begin
                    q_pop      = 1'b1;
                    op_next    = q_item.op;
                    key_next   = q_item.key;
                    nest_next  = 1'b0;
                    start_next = oldest_reg;
                    lvl_next   = oldest_reg;
                    iss_next   = 3'd0;
                    rx_next    = 3'd0;
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                if (iss_reg < nh)
                begin
                    hreq.valid = 1'b1;
                    iss_next   = iss_reg + 3'd1;
                end
                if (hresp.valid)
                begin
                    if (nest_reg)
                        mh_next[hresp.tag] = hresp.hash;
                    else
                        h_next[hresp.tag] = hresp.hash;
                    rx_next = rx_reg + 3'd1;
                    if (rx_reg + 3'd1 == nh)
                        state_next = ST_LEVEL;
                end
            end
            ST_LEVEL:
            begin
                if (cur_j < live_reg)
                begin
                    if (nest_reg)
                    begin
                        mhi_next = 2'd0;
                    end
                    else
                    begin
                        hi_next   = 2'd0;
                        copy_next = (op_reg == OP_INSERT) && (lvl_reg == oldest_reg)
                                    && (live_reg - oldest_reg > LVL_W'(1));
                    end
                    state_next = ST_PROBE;
                end
                else if (!nest_reg && op_reg == OP_QUERY)
                begin
                    do_ret = 1'b1;
                end
                else if (live_reg == LVL_W'(MAX_LEVELS))
                begin
                    do_ret = 1'b1;
                    ret_s  = 1'b1;
                end
                else
                begin
                    live_next = live_reg + 1'b1;
                    if (nest_reg)
                    begin
                        mstart_next = cur_start + 1'b1;
                        mlvl_next   = cur_start + 1'b1;
                    end
                    else
                    begin
                        start_next = cur_start + 1'b1;
                        lvl_next   = cur_start + 1'b1;
                    end
                end
            end
            ST_PROBE:
            begin
                addr_next  = ADDR_W'(base32 + (cur_h & mask32));
                mem_raddr  = addr_next;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (!rdata_reg[FLAG_OCC])
                begin
                    do_ret = 1'b1;
                    if (nest_reg || op_reg == OP_INSERT)
                    begin
                        mem_we = 1'b1;
                        ret_p  = 1'b1;
                    end
                end
                else if (rdata_reg[63:0] == cur_key)
                begin
                    do_ret = 1'b1;
                    ret_p  = (op_reg == OP_QUERY);
                end
                else if (!nest_reg && copy_reg && !rdata_reg[FLAG_MOVED])
                begin
                    mem_we      = 1'b1;
                    mem_wdata   = rdata_reg | 66'(1) << FLAG_MOVED;
                    mkey_next   = rdata_reg[63:0];
                    nest_next   = 1'b1;
                    mstart_next = lvl_reg + 1'b1;
                    mlvl_next   = lvl_reg + 1'b1;
                    iss_next    = 3'd0;
                    rx_next     = 3'd0;
                    state_next  = ST_HASH;
                end
                else
                begin
                    do_adv = 1'b1;
                end
            end
            ST_MIGDONE:
            begin
                moved_next[lvl_reg[IDX_W-1:0]] = moved_reg[lvl_reg[IDX_W-1:0]] + 1'b1;
                if ((32'(moved_reg[lvl_reg[IDX_W-1:0]]) + 32'd1 == size32)
                    && (oldest_reg == lvl_reg) && (lvl_reg + 1'b1 < live_reg))
                    oldest_next = lvl_reg + 1'b1;
                do_adv = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (do_adv)
        begin
            if (3'(cur_hi) + 3'd1 == nh)
            begin
                if (nest_reg)
                    mlvl_next = mlvl_reg + 1'b1;
                else
                    lvl_next = lvl_reg + 1'b1;
                state_next = ST_LEVEL;
            end
            else
            begin
                if (nest_reg)
                    mhi_next = mhi_reg + 2'd1;
                else
                    hi_next = hi_reg + 2'd1;
                state_next = ST_PROBE;
            end
        end

        if (do_ret)
        begin
            if (nest_reg)
            begin
                nest_next  = 1'b0;
                state_next = ST_MIGDONE;
            end
            else
            begin
                outv_next  = 1'b1;
                pres_next  = ret_p;
                stat_next  = ret_s;
                state_next = ST_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            nest_reg   <= 1'b0;
            live_reg   <= LVL_W'(1);
            oldest_reg <= '0;
            iss_reg    <= '0;
            rx_reg     <= '0;
            outv_reg   <= 1'b0;
            for (int i = 0; i < MAX_LEVELS; i++)
            begin
                moved_reg[i] <= '0;
            end
            hc_reg <= 3'd1;
            for (int i = 0; i < 4; i++)
            begin
                seed_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            nest_reg   <= nest_next;
            live_reg   <= live_next;
            oldest_reg <= oldest_next;
            iss_reg    <= iss_next;
            rx_reg     <= rx_next;
            outv_reg   <= outv_next;
            moved_reg  <= moved_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_HASH_COUNT: hc_reg      <= cfg_data[2:0];
                    CFG_SEED_0:     seed_reg[0] <= cfg_data;
                    CFG_SEED_1:     seed_reg[1] <= cfg_data;
                    CFG_SEED_2:     seed_reg[2] <= cfg_data;
                    CFG_SEED_3:     seed_reg[3] <= cfg_data;
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        mkey_reg   <= mkey_next;
        h_reg      <= h_next;
        mh_reg     <= mh_next;
        start_reg  <= start_next;
        lvl_reg    <= lvl_next;
        mstart_reg <= mstart_next;
        mlvl_reg   <= mlvl_next;
        hi_reg     <= hi_next;
        mhi_reg    <= mhi_next;
        copy_reg   <= copy_next;
        addr_reg   <= addr_next;
        pres_reg   <= pres_next;
        stat_reg   <= stat_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    assign out_valid = outv_reg;
    assign present   = pres_reg;
    assign status    = stat_reg;

endmodule

### design/multilevel_multiprobe_hash_set.sv
// Multi-level hash set of 64-bit keys with lazy migration between levels.
// Input channel s_*: tuser selects query (0) or insert (1), tdata carries the key.
// Output channel m_*: one transaction per input, tdata bit 0 present, bit 1 status
// (insert failed, all levels full).
// Configuration: cfg_we/cfg_index/cfg_data write hash_count (0) and seed_0..3 (1..4);
// write only while the block is idle.
// Items pass a two-entry input queue to a sequencer that owns the slot memory.
// Per item: the hash requests are issued and pass the murmur pipeline, then each
// probe is a memory read and a check/write, plus a level step per level visited. A
// migration adds one more hash pass, its own probes and a bookkeeping step.
// The sequencer finishes one item before it takes the next from the queue.
// After reset the slot memory is cleared, one entry a cycle, across all
// 16 * (2**MAX_LEVELS - 1) entries (240 at default); no item is taken until then.
// A stalled receiver holds the result in the output register; the queue still
// takes up to two more transactions, and the next item starts once the result
// is taken.
module multilevel_multiprobe_hash_set
    import mmhs_pkg::*;
#(
    parameter int MAX_LEVELS = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // key
    input  logic        s_tuser,  // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,  // present, status, zero fill
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

`include "multilevel_multiprobe_hash_set_defines.svh"

    logic       q_valid, q_pop;
    item_t      q_item;
    hash_req_t  hreq;
    hash_resp_t hresp;
    logic       present, status;

    mmhs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    mmhs_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (hreq),
        .resp  (hresp)
    );

    mmhs_engine #(
        .MAX_LEVELS (MAX_LEVELS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .hreq      (hreq),
        .hresp     (hresp),
        .m_tready  (m_tready),
        .out_valid (m_tvalid),
        .present   (present),
        .status    (status)
    );

    assign m_tdata = {6'b0, status, present};

    `MMHS_ASSERT_IMPL(a_pop_has_item, q_pop, q_valid)
    `MMHS_ASSERT_IMPL(a_full_not_stored, m_tvalid, !(present && status))
    `MMHS_ASSERT_IMPL(a_no_pop_while_hashing, hresp.valid, !q_pop)

endmodule
